// ===== sv/tms_pkg.sv =====
// Shared types and fixed widths for the triangle midpoint subdivider.
// No dependencies; imported by tms_norm, tms_back and the top level.
package tms_pkg;

  // Midpoint magnitude after pre-shift: at most 2^16
  localparam int MAG_W  = 17;
  // Sum of three squared magnitudes: at most 3 * 2^32
  localparam int LEN_W  = 34;
  // Radicand is the squared length scaled by 2^20
  localparam int RAD_W  = LEN_W + 20;
  localparam int ROOT_W = RAD_W / 2;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_CHK,
    N_ROOT,
    N_DLD,
    N_DIV,
    N_DST,
    N_DONE
  } norm_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PICK,
    B_WAIT,
    B_SEND
  } back_state_t;

  // Handshake between the back end and the normalizer
  typedef struct packed {
    logic start;
    logic done;
  } norm_ctl_t;

endpackage

// ===== sv/tms_front.sv =====
// Front end: accepts triangles and holds them in a two-entry queue.
// Depends on tms_pkg only by convention; no package items needed.
module tms_front #(
  parameter int ITEM_W = 145
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ITEM_W-1:0] in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [ITEM_W-1:0] q_item
);

  logic [ITEM_W-1:0] mem [2];
  logic              wp;
  logic              rp;
  logic [1:0]        fill;
  logic              push;
  logic              pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rp];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/tms_norm.sv =====
// Midpoint normalizer: sum of two corners scaled to unit length.
// Shared squarer, bit-serial square root and bit-serial divider; uses tms_pkg.
module tms_norm #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tms_pkg::norm_ctl_t   ctl_in,
  output tms_pkg::norm_ctl_t   ctl_out,
  input  logic [3*CW-1:0]      p,
  input  logic [3*CW-1:0]      q,
  output logic [3*CW-1:0]      res
);
  import tms_pkg::*;

  localparam int PRE  = (CW > 16) ? (CW - 16) : 0;
  localparam int DW   = MAG_W + CW + 8 + 1;
  localparam int CNTW = $clog2(((ROOT_W > CW) ? ROOT_W : CW) + 1);

  norm_state_t       state;
  norm_state_t       state_next;
  logic [MAG_W-1:0]  mag [3];
  logic [2:0]        neg;
  logic [1:0]        idx;
  logic [LEN_W-1:0]  len;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rrem;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] drem;
  logic [CW-1:0]     dsh;
  logic [CNTW-1:0]   cnt;
  logic [CW-1:0]     res_r [3];

  logic [MAG_W-1:0]  mag_in [3];
  logic [2:0]        neg_in;
  logic [ROOT_W+3:0] sq_t;
  logic [ROOT_W+3:0] sq_trial;
  logic [ROOT_W:0]   dv_t;
  logic              dv_ge;
  logic [DW-1:0]     dividend;

  // Sum, sign and pre-shifted magnitude of each midpoint coordinate
  always_comb begin
    logic signed [CW:0] s;
    logic [CW:0]        a;
    for (int i = 0; i < 3; i++) begin
      s = (CW+1)'($signed(p[i*CW +: CW])) + (CW+1)'($signed(q[i*CW +: CW]));
      neg_in[i] = s[CW];
      a = s[CW] ? (CW+1)'(-s) : (CW+1)'(s);
      mag_in[i] = MAG_W'(a >> PRE);
    end
  end

  // Root and divide step terms
  assign sq_t     = {rrem, rad[RAD_W-1 -: 2]};
  assign sq_trial = (ROOT_W+4)'({root, 2'b01});
  assign dv_t     = {drem, dsh[CW-1]};
  assign dv_ge    = (dv_t >= {1'b0, root});
  assign dividend = (DW'(mag[idx]) << (CW + 8)) + DW'(root >> 1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE: if (ctl_in.start) state_next = N_SQ;
      N_SQ:   if (idx == 2'd2) state_next = N_CHK;
      N_CHK:  state_next = (len == '0) ? N_DONE : N_ROOT;
      N_ROOT: if (cnt == CNTW'(ROOT_W - 1)) state_next = N_DLD;
      N_DLD:  state_next = N_DIV;
      N_DIV:  if (cnt == CNTW'(CW - 1)) state_next = N_DST;
      N_DST:  state_next = (idx == 2'd2) ? N_DONE : N_DLD;
      N_DONE: state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = (state == N_DONE);

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag_in[i];
        end
        neg <= neg_in;
        idx <= 2'd0;
        len <= '0;
      end
      N_SQ: begin
        len <= len + LEN_W'(mag[idx]) * LEN_W'(mag[idx]);
        idx <= idx + 2'd1;
      end
      N_CHK: begin
        rad  <= RAD_W'({len, 20'b0});
        rrem <= '0;
        root <= '0;
        cnt  <= '0;
        idx  <= 2'd0;
        if (len == '0) begin
          for (int i = 0; i < 3; i++) begin
            res_r[i] <= '0;
          end
        end
      end
      N_ROOT: begin
        if (sq_t >= sq_trial) begin
          rrem <= (ROOT_W+2)'(sq_t - sq_trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rrem <= (ROOT_W+2)'(sq_t);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        rad <= rad << 2;
        cnt <= cnt + CNTW'(1);
      end
      N_DLD: begin
        drem <= ROOT_W'(dividend >> CW);
        dsh  <= dividend[CW-1:0];
        cnt  <= '0;
      end
      N_DIV: begin
        drem <= dv_ge ? ROOT_W'(dv_t - {1'b0, root}) : ROOT_W'(dv_t);
        dsh  <= {dsh[CW-2:0], dv_ge};
        cnt  <= cnt + CNTW'(1);
      end
      N_DST: begin
        res_r[idx] <= neg[idx] ? CW'(-dsh) : dsh;
        idx        <= idx + 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign res = {res_r[2], res_r[1], res_r[0]};

endmodule

// ===== sv/tms_back.sv =====
// Back end: emits three corners and three normalized midpoints per triangle.
// Drives tms_norm, owns the vertex counter and output register; uses tms_pkg.
module tms_back #(
  parameter int CW   = 16,
  parameter int MAXV = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [9*CW:0]     q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3*CW-1:0]   out_pos,
  output logic [15:0]       out_index,
  output logic              out_last
);
  import tms_pkg::*;

  localparam int CNTW = (MAXV > 1) ? $clog2(MAXV) : 1;

  back_state_t       state;
  back_state_t       state_next;
  logic [9*CW:0]     tri_r;
  logic [2:0]        k;
  logic [CNTW-1:0]   cnt;
  logic [3*CW-1:0]   res;
  norm_ctl_t         nctl_in;
  norm_ctl_t         nctl_out;
  logic [3*CW-1:0]   np;
  logic [3*CW-1:0]   nq;
  logic [3*CW-1:0]   nres;
  logic              send;

  logic [3*CW-1:0]   va;
  logic [3*CW-1:0]   vb;
  logic [3*CW-1:0]   vc;

  assign va = tri_r[0 +: 3*CW];
  assign vb = tri_r[3*CW +: 3*CW];
  assign vc = tri_r[6*CW +: 3*CW];

  // Edge pairs: ab, bc, ac
  always_comb begin
    case (k)
      3'd3:    begin np = va; nq = vb; end
      3'd4:    begin np = vb; nq = vc; end
      default: begin np = va; nq = vc; end
    endcase
  end

  tms_norm #(.CW(CW)) u_norm (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (nctl_in),
    .ctl_out (nctl_out),
    .p       (np),
    .q       (nq),
    .res     (nres)
  );

  assign send          = (state == B_SEND) && (!out_valid || out_ready);
  assign q_ready       = (state == B_IDLE);
  assign nctl_in.start = (state == B_PICK) && (k >= 3'd3);
  assign nctl_in.done  = 1'b0;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid) state_next = B_PICK;
      B_PICK: state_next = (k < 3'd3) ? B_SEND : B_WAIT;
      B_WAIT: if (nctl_out.done) state_next = B_SEND;
      B_SEND: if (send) state_next = (k == 3'd5) ? B_IDLE : B_PICK;
      default: state_next = B_IDLE;
    endcase
  end

  // Hold triangle, pick the vertex, capture midpoints
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      tri_r <= q_item;
    end
    if (state == B_PICK) begin
      case (k)
        3'd0:    res <= va;
        3'd1:    res <= vb;
        default: res <= vc;
      endcase
    end
    if (state == B_WAIT && nctl_out.done) begin
      res <= nres;
    end
    if (send) begin
      out_pos   <= res;
      out_index <= 16'(cnt);
      out_last  <= (k == 3'd5);
    end
  end

  // Advance vertex step, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= 3'd0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_IDLE && q_valid) begin
        k <= 3'd0;
        if (q_item[9*CW]) begin
          cnt <= '0;
        end
      end
      if (send) begin
        out_valid <= 1'b1;
        k         <= k + 3'd1;
        cnt       <= (cnt == CNTW'(MAXV - 1)) ? '0 : cnt + CNTW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/triangle_midpoint_subdivider.sv =====
// Triangle midpoint subdivider: one icosphere subdivision step per triangle.
// Instantiates tms_front and tms_back (which holds tms_norm); uses tms_pkg.
//
// Input channel (s_*): one triangle per item, corners a, b, c as signed fixed
// point with COORD_WIDTH bits, two of them integer. s_tuser is start_level:
// it clears the vertex counter before this triangle.
// Output channel (m_*): six vertices per triangle, corners a, b, c, then the
// unit-length midpoints of ab, bc, ac. Each carries its running vertex index
// (low 16 bits, wrapping at MAX_VERTICES); m_tlast marks the sixth.
// Corners are copied out as they are; each midpoint waits on the shared
// one-bit square root and divider (ROOT_W = 27). Each output also waits
// on m_tready while the output register is full.
// A two-entry queue takes new triangles while the back end works, but the
// back end stalls while its output register waits on m_tready.
// Reset clears the queue, the counter and the output valid.
module triangle_midpoint_subdivider #(
  parameter int MAX_VERTICES = 65536,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero padded
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // start_level
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pos_x, pos_y, pos_z, vertex_index from bit 0 up, zero padded
  output logic [((3*COORD_WIDTH+16+7)/8)*8-1:0] m_tdata,
  output logic                   m_tlast
);
  import tms_pkg::*;

  localparam int IN_W  = 9 * COORD_WIDTH;
  localparam int OUT_W = 3 * COORD_WIDTH + 16;
  localparam int OUT_B = ((OUT_W + 7) / 8) * 8;

  logic              q_valid;
  logic              q_ready;
  logic [IN_W:0]     q_item;
  logic [3*COORD_WIDTH-1:0] pos;
  logic [15:0]       vidx;

  tms_front #(.ITEM_W(IN_W + 1)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  ({s_tuser, s_tdata[IN_W-1:0]}),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tms_back #(.CW(COORD_WIDTH), .MAXV(MAX_VERTICES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (pos),
    .out_index (vidx),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUT_B'({vidx, pos});

endmodule
